/* sv/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and helpers for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int UNIT_W   = 16;
    localparam int CP_W     = 21;
    localparam int SUM_W    = 32;
    localparam int TRAIL_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 21;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_REPL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODE_REPL = 1'd1;

    // Codepoint limits and surrogate constants
    localparam logic [SUM_W-1:0]  CP_MAX       = 32'h0010_FFFF;
    localparam logic [SUM_W-1:0]  BMP_MAX      = 32'h0000_FFFF;
    localparam logic [SUM_W-1:0]  SURR_LO      = 32'h0000_D800;
    localparam logic [SUM_W-1:0]  SURR_HI      = 32'h0000_DFFF;
    // High surrogate is D800 plus (cp - 10000) >> 10, i.e. D7C0 plus cp[20:10].
    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD7C0;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;

    // Input request: one byte of the stream
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_final;
    } t_in_item;

    // Output request: one UTF-16 code unit
    typedef struct packed {
        logic [UNIT_W-1:0] out_unit;
        logic              out_run_end;
    } t_out_item;

    // Work handed from the front part to the back part: a raw sum and the
    // trailing count that selects the offset to subtract.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [TRAIL_W-1:0] trail;
    } t_job;

    // Queue head as seen by the back part
    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue_head;

    // Number of trailing bytes announced by a lead byte (lenient table).
    function automatic logic [TRAIL_W-1:0] trail_of(input logic [BYTE_W-1:0] b);
        logic [TRAIL_W-1:0] t;
        begin
            unique casez (b)
                8'b0???_????, 8'b10??_????: t = 3'd0;
                8'b110?_????:               t = 3'd1;
                8'b1110_????:               t = 3'd2;
                8'b1111_0???:               t = 3'd3;
                8'b1111_10??:               t = 3'd4;
                default:                    t = 3'd5;
            endcase
            return t;
        end
    endfunction

    // Offset removed from the shifted sum of a sequence; the count wraps at six.
    function automatic logic [SUM_W-1:0] seq_offset(input logic [TRAIL_W-1:0] t);
        logic [SUM_W-1:0] o;
        begin
            case (t)
                3'd1:    o = 32'h0000_3080;
                3'd2:    o = 32'h000E_2080;
                3'd3:    o = 32'h03C8_2080;
                3'd4:    o = 32'hFA08_2080;
                3'd5:    o = 32'h8208_2080;
                3'd7:    o = 32'h0000_3080;
                default: o = 32'h0000_0000;
            endcase
            return o;
        end
    endfunction

endpackage

/* sv/utf8_to_utf16_transcoder_unit.sv */
// A completing byte's job is written into the job queue as the byte is accepted,
// and its first unit is then loaded from the queue head into the output register.
// Throughput: one byte per cycle while o_stall is low; a surrogate pair holds the output
// register for both its units, which the two-slot job queue absorbs for one following byte.
// Reset: synchronous, active low; clears the open sequence, the queue, the
// output register's valid flag and both configuration registers.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// Top level: configuration registers, front decoder, job queue and emitter.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  u8u16_pkg::t_in_item                 i_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output u8u16_pkg::t_out_item                o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [u8u16_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [u8u16_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    logic [u8u16_pkg::CP_W-1:0]   r_decode_repl;
    logic [u8u16_pkg::UNIT_W-1:0] r_encode_repl;

    logic                   in_accept;
    logic                   push;
    u8u16_pkg::t_job        job;
    logic                   pop;
    logic                   full;
    u8u16_pkg::t_queue_head head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign in_accept   = i_valid && !full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_repl <= '0;
            r_encode_repl <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                u8u16_pkg::CFG_DECODE_REPL: r_decode_repl <= i_cfg_data;
                u8u16_pkg::CFG_ENCODE_REPL: r_encode_repl <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    u8u16_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_item        (i_in),
        .i_decode_repl (r_decode_repl),
        .o_push        (push),
        .o_job         (job)
    );

    u8u16_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    u8u16_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_encode_repl (r_encode_repl),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_item        (o_out)
    );

endmodule

/* sv/u8u16_front.sv */
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts stream bytes, tracks the open sequence and hands finished
// codepoint sums, or the decode replacement, to the job queue.
// ----------------------------------------------------------------------------
module u8u16_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  u8u16_pkg::t_in_item                    i_item,
    input  logic [u8u16_pkg::CP_W-1:0]             i_decode_repl,
    output logic                                   o_push,
    output u8u16_pkg::t_job                        o_job
);

    logic [u8u16_pkg::SUM_W-1:0]   r_acc,    n_acc;
    logic [u8u16_pkg::TRAIL_W-1:0] r_remain, n_remain;
    logic [u8u16_pkg::TRAIL_W-1:0] r_trail,  n_trail;

    logic [u8u16_pkg::TRAIL_W-1:0] lead_trail;
    logic [u8u16_pkg::SUM_W-1:0]   shifted_sum;
    logic [u8u16_pkg::TRAIL_W-1:0] remain_dec;
    logic [u8u16_pkg::SUM_W-1:0]   byte_ext;
    logic [u8u16_pkg::SUM_W-1:0]   repl_ext;

    assign byte_ext    = {{(u8u16_pkg::SUM_W-u8u16_pkg::BYTE_W){1'b0}}, i_item.in_byte};
    assign repl_ext    = {{(u8u16_pkg::SUM_W-u8u16_pkg::CP_W){1'b0}}, i_decode_repl};
    assign lead_trail  = u8u16_pkg::trail_of(i_item.in_byte);
    assign shifted_sum = {r_acc[u8u16_pkg::SUM_W-7:0], 6'b0} + byte_ext;
    assign remain_dec  = r_remain - 3'd1;

    // Sequence tracking and job generation for each accepted request.
    always_comb begin
        n_acc    = r_acc;
        n_remain = r_remain;
        n_trail  = r_trail;
        o_push   = 1'b0;
        o_job    = '{sum: byte_ext, trail: '0};
        if (i_accept) begin
            if (r_remain == '0) begin
                if (lead_trail == '0) begin
                    // Single byte, including a lone continuation byte.
                    o_push = 1'b1;
                    o_job  = '{sum: byte_ext, trail: '0};
                end else if (i_item.in_final) begin
                    // Stream ends on a multi-byte lead.
                    o_push = 1'b1;
                    o_job  = '{sum: repl_ext, trail: '0};
                end else begin
                    n_acc    = byte_ext;
                    n_remain = lead_trail;
                    n_trail  = lead_trail;
                end
            end else begin
                if (remain_dec == '0) begin
                    o_push   = 1'b1;
                    o_job    = '{sum: shifted_sum, trail: r_trail};
                    n_acc    = '0;
                    n_remain = '0;
                    n_trail  = '0;
                end else if (i_item.in_final) begin
                    // Stream ends inside a sequence.
                    o_push   = 1'b1;
                    o_job    = '{sum: repl_ext, trail: '0};
                    n_acc    = '0;
                    n_remain = '0;
                    n_trail  = '0;
                end else begin
                    n_acc    = shifted_sum;
                    n_remain = remain_dec;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_remain <= '0;
            r_trail  <= '0;
        end else begin
            r_acc    <= n_acc;
            r_remain <= n_remain;
            r_trail  <= n_trail;
        end
    end

endmodule

/* sv/u8u16_queue.sv */
// ----------------------------------------------------------------------------
// u8u16_queue
// Two-slot job queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module u8u16_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  u8u16_pkg::t_job        i_job,
    input  logic                   i_pop,
    output logic                   o_full,
    output u8u16_pkg::t_queue_head o_head
);

    u8u16_pkg::t_job r_slot0, r_slot1;
    logic            r_wr_ptr, r_rd_ptr;
    logic [1:0]      r_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.job   = r_rd_ptr ? r_slot1 : r_slot0;

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push && !r_wr_ptr) begin
            r_slot0 <= i_job;
        end
        if (i_push && r_wr_ptr) begin
            r_slot1 <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/u8u16_back.sv */
// ----------------------------------------------------------------------------
// u8u16_back
// Removes the sequence offset, classifies the codepoint and emits one unit,
// a surrogate pair or, when it is nonzero, the encode replacement through an output register.
// ----------------------------------------------------------------------------
module u8u16_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  u8u16_pkg::t_queue_head           i_head,
    input  logic [u8u16_pkg::UNIT_W-1:0]     i_encode_repl,
    input  logic                             i_stall,
    output logic                             o_pop,
    output logic                             o_valid,
    output u8u16_pkg::t_out_item             o_item
);

    logic                            r_out_valid, n_out_valid;
    u8u16_pkg::t_out_item            r_out,       n_out;
    logic                            r_pend,      n_pend;
    logic [u8u16_pkg::UNIT_W-1:0]    r_pend_unit, n_pend_unit;

    logic                            load;
    logic [u8u16_pkg::SUM_W-1:0]     cp;
    logic                            is_single;
    logic                            is_pair;
    logic [u8u16_pkg::UNIT_W-1:0]    hi_unit;
    logic [u8u16_pkg::UNIT_W-1:0]    lo_unit;

    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign load    = !r_out_valid || !i_stall;
    assign o_pop   = load && !r_pend && i_head.valid;

    // Codepoint and its class.
    assign cp        = i_head.job.sum - u8u16_pkg::seq_offset(i_head.job.trail);
    assign is_single = (cp <= u8u16_pkg::BMP_MAX)
                       && ((cp < u8u16_pkg::SURR_LO) || (cp > u8u16_pkg::SURR_HI));
    assign is_pair   = (cp > u8u16_pkg::BMP_MAX) && (cp <= u8u16_pkg::CP_MAX);
    assign hi_unit   = u8u16_pkg::HI_SURR_BASE + {5'b0, cp[20:10]};
    assign lo_unit   = u8u16_pkg::LO_SURR_BASE | {6'b0, cp[9:0]};

    // Output register loading: a waiting low surrogate goes first.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pend      = r_pend;
        n_pend_unit = r_pend_unit;
        if (load) begin
            n_out_valid = 1'b0;
            if (r_pend) begin
                n_out_valid = 1'b1;
                n_out       = '{out_unit: r_pend_unit, out_run_end: 1'b1};
                n_pend      = 1'b0;
            end else if (i_head.valid) begin
                if (is_single) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_unit: cp[15:0], out_run_end: 1'b1};
                end else if (is_pair) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_unit: hi_unit, out_run_end: 1'b0};
                    n_pend      = 1'b1;
                    n_pend_unit = lo_unit;
                end else if (i_encode_repl != '0) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_unit: i_encode_repl, out_run_end: 1'b1};
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_pend_unit <= n_pend_unit;
    end

endmodule

/* sv/u8u16_checker.sv */
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the transcoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input u8u16_pkg::t_out_item o_out
);

    // A stalled output request keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output request changed while stalled");

    // Only the high half of a surrogate pair leaves a run open.
    a_open_is_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.out_run_end |-> o_out.out_unit[15:10] == 6'h36)
        else $error("open run on a unit that is not a high surrogate");

    // A taken high surrogate is followed at once by its low surrogate.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_out.out_run_end
        |=> o_valid && o_out.out_run_end && o_out.out_unit[15:10] == 6'h37)
        else $error("low surrogate did not follow the high surrogate");

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
